>>> hw/rtl/spdw_pkg.sv
// ----------------------------------------------------------------------------
// spdw_pkg
// shared types and constants for the sorted pool with worst-entry displacement
// ----------------------------------------------------------------------------
package spdw_pkg;

  localparam int COST_BITS         = 32;
  localparam int IDX_BITS          = 6;
  localparam int TAG_IO_BITS       = 16;
  localparam int POOL_ENTRIES_DEF  = 64;
  localparam int TAG_BITS_DEF      = 16;

  localparam logic [COST_BITS-1:0] COST_INVALID = '1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [COST_BITS-1:0]   new_cost;
    logic [TAG_IO_BITS-1:0] new_tag;
    logic [IDX_BITS-1:0]    read_index;
  } req_t;

  typedef struct packed {
    logic                   accepted;
    logic [IDX_BITS-1:0]    insert_position;
    logic [COST_BITS-1:0]   out_cost;
    logic [TAG_IO_BITS-1:0] out_tag;
  } rsp_t;

endpackage

>>> hw/rtl/spdw_cell.sv
// ----------------------------------------------------------------------------
// spdw_cell
// one pool slot: holds a cost and a tag, compares against the incoming cost
// and takes either the new entry or its upper neighbour's entry on insert
// ----------------------------------------------------------------------------
module spdw_cell #(
  parameter int TAG_BITS = spdw_pkg::TAG_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           ins,
  input  logic [spdw_pkg::COST_BITS-1:0] new_cost,
  input  logic [TAG_BITS-1:0]            new_tag,
  input  logic                           prev_ge,
  input  logic [spdw_pkg::COST_BITS-1:0] prev_cost,
  input  logic [TAG_BITS-1:0]            prev_tag,
  output logic                           ge,
  output logic [spdw_pkg::COST_BITS-1:0] cost,
  output logic [TAG_BITS-1:0]            tag
);
  import spdw_pkg::*;

  // stored cost at or above the new one: this slot moves
  assign ge = (cost >= new_cost);

  always_ff @(posedge clk) begin
    if (rst) begin
      cost <= COST_INVALID;
      tag  <= '0;
    end else if (ins && ge) begin
      if (prev_ge) begin
        cost <= prev_cost;
        tag  <= prev_tag;
      end else begin
        cost <= new_cost;
        tag  <= new_tag;
      end
    end
  end

endmodule

>>> hw/rtl/sorted_pool_displace_worst.sv
// ----------------------------------------------------------------------------
// sorted_pool_displace_worst
// bounded pool of cost/tag entries kept sorted best first, worst displaced
// ----------------------------------------------------------------------------
// response: registered on the clock edge that accepts the request
// throughput: one request per cycle, insert or read, while the response register
// drains; the cell row compares and shifts every slot together
// reset: synchronous; every slot becomes cost all ones (invalid)
// with tag zero, and the response register empties
// ----------------------------------------------------------------------------
module sorted_pool_displace_worst #(
  parameter int POOL_ENTRIES = spdw_pkg::POOL_ENTRIES_DEF,
  parameter int TAG_BITS     = spdw_pkg::TAG_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  spdw_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output spdw_pkg::rsp_t rsp
);
  import spdw_pkg::*;

  // only the first 64 slots are reachable by a read index
  localparam int READ_CELLS = (POOL_ENTRIES < (1 << IDX_BITS)) ?
                              POOL_ENTRIES : (1 << IDX_BITS);

  logic                 accept;
  logic                 ins;
  logic [TAG_BITS+TAG_IO_BITS-1:0] tag_in_ext;
  logic [TAG_BITS-1:0]  tag_in;

  logic [POOL_ENTRIES-1:0] ge;
  logic [POOL_ENTRIES-1:0] prev_ge;
  logic [COST_BITS-1:0]    cell_cost [POOL_ENTRIES];
  logic [TAG_BITS-1:0]     cell_tag  [POOL_ENTRIES];
  logic [COST_BITS-1:0]    prev_cost [POOL_ENTRIES];
  logic [TAG_BITS-1:0]     prev_tag  [POOL_ENTRIES];

  logic [IDX_BITS-1:0]     position;
  logic                    rd_hit;
  logic [COST_BITS-1:0]    rd_cost;
  logic [TAG_BITS-1:0]     rd_tag;
  logic [TAG_IO_BITS+TAG_BITS-1:0] rd_tag_ext;

  rsp_t rsp_next;

  // response register parts the two sides: a new request goes in while the
  // slot is empty or being drained this cycle
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign ins       = accept && (req.op == OP_INSERT);

  // tag kept in TAG_BITS bits: zero-extend or truncate the 16-bit field
  assign tag_in_ext = {{TAG_BITS{1'b0}}, req.new_tag};
  assign tag_in     = tag_in_ext[TAG_BITS-1:0];

  // neighbour links; slot 0 has nothing above it
  always_comb begin
    prev_ge[0]   = 1'b0;
    prev_cost[0] = COST_INVALID;
    prev_tag[0]  = '0;
    for (int i = 1; i < POOL_ENTRIES; i++) begin
      prev_ge[i]   = ge[i-1];
      prev_cost[i] = cell_cost[i-1];
      prev_tag[i]  = cell_tag[i-1];
    end
  end

  // row of cells, best at slot 0; the ge flags are monotonic because the
  // row stays sorted, so the new entry lands at the first set flag and every
  // later slot takes its neighbour's entry. when the last slot's flag is
  // clear nothing moves, which is the reject case
  for (genvar g = 0; g < POOL_ENTRIES; g++) begin : g_cell
    spdw_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ins       (ins),
      .new_cost  (req.new_cost),
      .new_tag   (tag_in),
      .prev_ge   (prev_ge[g]),
      .prev_cost (prev_cost[g]),
      .prev_tag  (prev_tag[g]),
      .ge        (ge[g]),
      .cost      (cell_cost[g]),
      .tag       (cell_tag[g])
    );
  end

  // insert position: encode the one-hot boundary, low six bits only
  always_comb begin
    position = '0;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      position = position | ({IDX_BITS{ge[i] && !prev_ge[i]}} & IDX_BITS'(i));
    end
  end

  // read: and-or select over the addressable slots
  always_comb begin
    rd_hit  = 1'b0;
    rd_cost = '0;
    rd_tag  = '0;
    for (int i = 0; i < READ_CELLS; i++) begin
      if (req.read_index == IDX_BITS'(i)) begin
        rd_hit  = 1'b1;
        rd_cost = rd_cost | cell_cost[i];
        rd_tag  = rd_tag | cell_tag[i];
      end
    end
    // index past the pool reads as an invalid entry
    if (!rd_hit) begin
      rd_cost = COST_INVALID;
      rd_tag  = '0;
    end
  end

  assign rd_tag_ext = {{TAG_IO_BITS{1'b0}}, rd_tag};

  always_comb begin
    rsp_next = '0;
    case (req.op)
      OP_READ: begin
        rsp_next.out_cost = rd_cost;
        rsp_next.out_tag  = rd_tag_ext[TAG_IO_BITS-1:0];
      end
      OP_INSERT: begin
        rsp_next.accepted = ge[POOL_ENTRIES-1];
        if (ge[POOL_ENTRIES-1]) begin
          rsp_next.insert_position = position;
        end
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule
